// ===== hw/rtl/ccsoc_pkg.sv =====
// ----------------------------------------------------------------------------
// ccsoc_pkg
// Shared types and constants for the coulomb counter block.
// ----------------------------------------------------------------------------
package ccsoc_pkg;

  localparam int CHARGE_BITS_DEF = 42;

  localparam int OP_W   = 2;
  localparam int CAP_W  = 20;
  localparam int MS_W   = 16;
  localparam int CUR_W  = 20;
  localparam int REM_W  = 20;
  localparam int SOC_W  = 14;
  localparam int PROD_W = MS_W + 1 + CUR_W - 1;
  localparam int MAMS_W = 22;
  localparam int FULL_W = CAP_W + MAMS_W;

  localparam logic [MAMS_W-1:0] MAMS_PER_MAH = 22'd3600000;
  localparam logic [SOC_W-1:0]  SOC_SCALE    = 14'd10000;
  localparam logic [CAP_W-1:0]  CAP_RESET    = 20'd10000;

  // mA*ms per mAh is 2^7 * 28125; y / 28125 is (y * MAH_RECIP) >> 46 for y < 2^35
  localparam int                     MAH_PRE_SHIFT  = 7;
  localparam int                     MAH_RECIP_W    = 32;
  localparam logic [MAH_RECIP_W-1:0] MAH_RECIP      = 32'd2501999793;
  localparam int                     MAH_POST_SHIFT = 46;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_FULL  = 2'd1,
    OP_EMPTY = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_UPD,
    S_PREP,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic mul;
    logic upd;
    logic prep;
    logic div_step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage

// ===== hw/rtl/coulomb_counter_soc.sv =====
// ----------------------------------------------------------------------------
// coulomb_counter_soc
// Flow: a transaction passes the multiply, update, prep, 14-step serial state
// of charge divide and output states; no new input is taken until it is handed
// off. The mAh readout is a reciprocal multiply.
// Input is taken again while a finished result waits in the output register.
// Reset: capacity 10000 mAh, charge zero, no result pending.
// ----------------------------------------------------------------------------
module coulomb_counter_soc #(
  parameter int CHARGE_BITS = ccsoc_pkg::CHARGE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ccsoc_pkg::CAP_W-1:0]        cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ccsoc_pkg::OP_W-1:0]         in_op,
  input  logic [ccsoc_pkg::MS_W-1:0]         in_elapsed_ms,
  input  logic signed [ccsoc_pkg::CUR_W-1:0] in_current_ma,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ccsoc_pkg::REM_W-1:0]        out_remaining_mah,
  output logic [ccsoc_pkg::SOC_W-1:0]        out_soc_centipercent,
  output logic                               out_at_full,
  output logic                               out_at_empty
);
  import ccsoc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ccsoc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ccsoc_dp #(
    .CHARGE_BITS (CHARGE_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_op                (in_op),
    .in_elapsed_ms        (in_elapsed_ms),
    .in_current_ma        (in_current_ma),
    .out_remaining_mah    (out_remaining_mah),
    .out_soc_centipercent (out_soc_centipercent),
    .out_at_full          (out_at_full),
    .out_at_empty         (out_at_empty)
  );

endmodule

// ===== hw/rtl/ccsoc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ccsoc_ctrl
// Sequencer for one transaction: multiply, update, prepare, divide, hand off result.
// ----------------------------------------------------------------------------
module ccsoc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  ccsoc_pkg::dp_status_t status,
  output ccsoc_pkg::ctrl_cmd_t  cmd
);
  import ccsoc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        in_stall = !rst_n;
        if (in_valid && rst_n) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/ccsoc_dp.sv =====
// ----------------------------------------------------------------------------
// ccsoc_dp
// Charge accumulator, clamp logic, serial soc divider and reciprocal mAh multiply.
// ----------------------------------------------------------------------------
module ccsoc_dp #(
  parameter int CHARGE_BITS = ccsoc_pkg::CHARGE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ccsoc_pkg::ctrl_cmd_t              cmd,
  output ccsoc_pkg::dp_status_t             status,
  input  logic                              cfg_we,
  input  logic [ccsoc_pkg::CAP_W-1:0]       cfg_wdata,
  input  logic [ccsoc_pkg::OP_W-1:0]        in_op,
  input  logic [ccsoc_pkg::MS_W-1:0]        in_elapsed_ms,
  input  logic signed [ccsoc_pkg::CUR_W-1:0] in_current_ma,
  output logic [ccsoc_pkg::REM_W-1:0]       out_remaining_mah,
  output logic [ccsoc_pkg::SOC_W-1:0]       out_soc_centipercent,
  output logic                              out_at_full,
  output logic                              out_at_empty
);
  import ccsoc_pkg::*;

  localparam int SW     = ((CHARGE_BITS > FULL_W) ? CHARGE_BITS : FULL_W) + 2;
  localparam int N_W    = FULL_W + SOC_W;
  localparam int CNT_W  = $clog2(SOC_W);
  localparam int Y_W    = FULL_W - MAH_PRE_SHIFT;
  localparam int Y_LO_W = Y_W / 2;
  localparam int Y_HI_W = Y_W - Y_LO_W;
  localparam int PH_W   = Y_HI_W + MAH_RECIP_W;
  localparam int PL_W   = Y_LO_W + MAH_RECIP_W;
  localparam int MP_W   = Y_W + MAH_RECIP_W;

  logic [CAP_W-1:0]       cap_r;
  logic [CHARGE_BITS-1:0] charge_r;
  logic [OP_W-1:0]        op_r;
  logic [MS_W-1:0]        ms_r;
  logic signed [CUR_W-1:0] cur_r;
  logic [PROD_W-1:0]      prod_r;
  logic [FULL_W-1:0]      full_r;
  logic                   flag_full_r, flag_empty_r;
  logic                   full_zero_r, soc_sat_r;
  logic [N_W-1:0]         n_r, d_r;
  logic [SOC_W-1:0]       q_r;
  logic [PH_W-1:0]        mh_r;
  logic [PL_W-1:0]        ml_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [REM_W-1:0]       out_rem_r;
  logic [SOC_W-1:0]       out_soc_r;
  logic                   out_full_r, out_empty_r;

  logic [SW-1:0]          charge_w, full_w, wmax_w, limit_w, sum_w;
  logic [Y_W-1:0]         y_w;
  logic [MP_W-1:0]        mprod_w;

  assign charge_w = SW'(charge_r);
  assign full_w   = SW'(full_r);
  assign wmax_w   = (SW'(1) << CHARGE_BITS) - SW'(1);
  assign limit_w  = (full_w < wmax_w) ? full_w : wmax_w;
  assign sum_w    = charge_w + {{(SW-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  assign y_w      = charge_w[FULL_W-1:MAH_PRE_SHIFT];
  assign mprod_w  = (MP_W'(mh_r) << Y_LO_W) + MP_W'(ml_r);

  assign status.div_last = (cnt_r == CNT_W'(SOC_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= CAP_RESET;
      charge_r <= '0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (cmd.upd) begin
        case (op_r)
          OP_TICK: begin
            if (sum_w[SW-1]) begin
              charge_r <= '0;
            end else if (sum_w > limit_w) begin
              charge_r <= limit_w[CHARGE_BITS-1:0];
            end else begin
              charge_r <= sum_w[CHARGE_BITS-1:0];
            end
          end
          OP_FULL: begin
            charge_r <= limit_w[CHARGE_BITS-1:0];
          end
          default: begin
            charge_r <= charge_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_op;
      ms_r  <= in_elapsed_ms;
      cur_r <= in_current_ma;
    end
    if (cmd.mul) begin
      prod_r <= $signed({1'b0, ms_r}) * cur_r;
      full_r <= FULL_W'(cap_r) * FULL_W'(MAMS_PER_MAH);
    end
    if (cmd.upd) begin
      case (op_r)
        OP_TICK: begin
          flag_empty_r <= sum_w[SW-1];
          flag_full_r  <= !sum_w[SW-1] && (sum_w > limit_w);
        end
        OP_FULL: begin
          flag_empty_r <= 1'b0;
          flag_full_r  <= 1'b1;
        end
        default: begin
          flag_empty_r <= 1'b0;
          flag_full_r  <= 1'b0;
        end
      endcase
    end
    if (cmd.prep) begin
      full_zero_r <= (full_r == '0);
      soc_sat_r   <= (charge_w >= full_w);
      n_r         <= N_W'(charge_w[FULL_W-1:0]) * N_W'(SOC_SCALE);
      d_r         <= N_W'(full_r) << (SOC_W - 1);
      q_r         <= '0;
      mh_r        <= PH_W'(y_w[Y_W-1:Y_LO_W]) * PH_W'(MAH_RECIP);
      ml_r        <= PL_W'(y_w[Y_LO_W-1:0]) * PL_W'(MAH_RECIP);
      cnt_r       <= '0;
    end
    if (cmd.div_step) begin
      cnt_r <= cnt_r + CNT_W'(1);
      // restoring divide of the scaled charge by the full charge
      if (n_r >= d_r) begin
        n_r <= n_r - d_r;
        q_r <= {q_r[SOC_W-2:0], 1'b1};
      end else begin
        q_r <= {q_r[SOC_W-2:0], 1'b0};
      end
      d_r <= d_r >> 1;
    end
    if (cmd.finish) begin
      out_rem_r   <= mprod_w[MAH_POST_SHIFT+REM_W-1:MAH_POST_SHIFT];
      out_full_r  <= flag_full_r;
      out_empty_r <= flag_empty_r;
      if (full_zero_r) begin
        out_soc_r <= '0;
      end else if (soc_sat_r) begin
        out_soc_r <= SOC_SCALE;
      end else begin
        out_soc_r <= q_r;
      end
    end
  end

  assign out_remaining_mah    = out_rem_r;
  assign out_soc_centipercent = out_soc_r;
  assign out_at_full          = out_full_r;
  assign out_at_empty         = out_empty_r;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for coulomb_counter_soc. A directed table covers the field
// extremes, every event type and the clamping corners. Random ticks and
// charge events follow over a series of capacity settings. Every result is
// compared field by field with its typed row or an in-bench accumulator model.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ccsoc_pkg::*;

  localparam int CHARGE_W    = CHARGE_BITS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 158;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = 60;
  localparam int MAX_SHOWN   = 40;
  localparam logic [OP_W-1:0]  OP_SPARE = 2'd3;
  localparam logic [CAP_W-1:0] CAP_MAX  = 20'hFFFFF;

  typedef struct packed {
    logic [REM_W-1:0] remaining_mah;
    logic [SOC_W-1:0] soc_centipercent;
    logic             at_full;
    logic             at_empty;
  } soc_reading_t;

  typedef struct packed {
    logic             set_cap;
    logic [CAP_W-1:0] cap;
    logic [OP_W-1:0]  op;
    logic [MS_W-1:0]  ms;
    logic [CUR_W-1:0] cur;
    logic             typed;
    soc_reading_t     want;
  } drill_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CAP_W-1:0]        cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [OP_W-1:0]         in_op = '0;
  logic [MS_W-1:0]         in_elapsed_ms = '0;
  logic signed [CUR_W-1:0] in_current_ma = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [REM_W-1:0]        out_remaining_mah;
  logic [SOC_W-1:0]        out_soc_centipercent;
  logic                    out_at_full;
  logic                    out_at_empty;

  logic [CHARGE_W-1:0] charge_acc = '0;
  logic [CAP_W-1:0]    capacity = CAP_RESET;
  soc_reading_t        reading_q[$];
  drill_row_t          drills[$];

  int err_cnt = 0;
  int shown = 0;
  int accepted = 0;
  int readings = 0;
  int full_clamps = 0;
  int empty_clamps = 0;
  int cap_settings = 0;
  int cycle_cnt = 0;
  int stall_left = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  coulomb_counter_soc DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_op                (in_op),
    .in_elapsed_ms        (in_elapsed_ms),
    .in_current_ma        (in_current_ma),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_remaining_mah    (out_remaining_mah),
    .out_soc_centipercent (out_soc_centipercent),
    .out_at_full          (out_at_full),
    .out_at_empty         (out_at_empty)
  );

  // charge update and readout for one accepted transaction
  function automatic soc_reading_t account(input logic [OP_W-1:0] op,
                                           input logic [MS_W-1:0] ms,
                                           input logic signed [CUR_W-1:0] cur);
    logic [63:0]  mams;
    logic [63:0]  scale;
    logic [63:0]  full_mams;
    logic [63:0]  width_max;
    logic [63:0]  lim;
    logic [63:0]  sum_u;
    logic [63:0]  acc_wide;
    logic [63:0]  rem;
    logic [63:0]  soc;
    longint       sum;
    soc_reading_t r;
    mams = 64'(MAMS_PER_MAH);
    scale = 64'(SOC_SCALE);
    full_mams = 64'(capacity);
    full_mams = full_mams * mams;
    width_max = (64'd1 << CHARGE_W) - 64'd1;
    lim = (full_mams < width_max) ? full_mams : width_max;
    r = '0;
    case (op)
      OP_TICK: begin
        sum = longint'(charge_acc) + longint'(ms) * longint'(cur);
        sum_u = sum;
        if (sum < 0) begin
          charge_acc = '0;
          r.at_empty = 1'b1;
        end else if (sum_u > lim) begin
          charge_acc = lim[CHARGE_W-1:0];
          r.at_full = 1'b1;
        end else begin
          charge_acc = sum_u[CHARGE_W-1:0];
        end
      end
      OP_FULL: begin
        charge_acc = lim[CHARGE_W-1:0];
        r.at_full = 1'b1;
      end
      default: ;
    endcase
    acc_wide = 64'(charge_acc);
    soc = 64'd0;
    if (full_mams != 64'd0) begin
      soc = (acc_wide * scale) / full_mams;
      if (soc > scale) soc = scale;
    end
    rem = acc_wide / mams;
    r.remaining_mah = rem[REM_W-1:0];
    r.soc_centipercent = soc[SOC_W-1:0];
    return r;
  endfunction

  function automatic void add_drill(input bit set_cap, input int cap,
                                    input logic [OP_W-1:0] op, input int ms, input int cur,
                                    input bit typed, input int rem, input int soc,
                                    input bit f, input bit e);
    drill_row_t row;
    row.set_cap = set_cap;
    row.cap = CAP_W'(cap);
    row.op = op;
    row.ms = MS_W'(ms);
    row.cur = CUR_W'(cur);
    row.typed = typed;
    row.want.remaining_mah = REM_W'(rem);
    row.want.soc_centipercent = SOC_W'(soc);
    row.want.at_full = f;
    row.want.at_empty = e;
    drills.push_back(row);
  endfunction

  task automatic flag_error(input string msg);
    err_cnt++;
    if (shown < MAX_SHOWN) begin
      $display("[%0t] mismatch on transaction %0d: %s", $time, readings, msg);
      shown++;
    end
  endtask

  task automatic check_reading();
    soc_reading_t exp;
    readings++;
    if (reading_q.size() == 0) begin
      flag_error("result with nothing expected");
    end else begin
      exp = reading_q.pop_front();
      if (out_remaining_mah !== exp.remaining_mah)
        flag_error($sformatf("remaining_mah got %0d want %0d",
                             out_remaining_mah, exp.remaining_mah));
      if (out_soc_centipercent !== exp.soc_centipercent)
        flag_error($sformatf("soc_centipercent got %0d want %0d",
                             out_soc_centipercent, exp.soc_centipercent));
      if (out_at_full !== exp.at_full)
        flag_error($sformatf("at_full got %b want %b", out_at_full, exp.at_full));
      if (out_at_empty !== exp.at_empty)
        flag_error($sformatf("at_empty got %b want %b", out_at_empty, exp.at_empty));
    end
  endtask

  task automatic drive_item(input logic [OP_W-1:0] op, input logic [MS_W-1:0] ms,
                            input logic [CUR_W-1:0] cur, input bit typed,
                            input soc_reading_t want);
    soc_reading_t got;
    in_valid <= 1'b1;
    in_op <= op;
    in_elapsed_ms <= ms;
    in_current_ma <= cur;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = account(op, ms, cur);
    if (got.at_full) full_clamps++;
    if (got.at_empty) empty_clamps++;
    reading_q.push_back(typed ? want : got);
    accepted++;
  endtask

  task automatic pause_sender(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (reading_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    capacity = value;
    cap_settings++;
  endtask

  task automatic random_item();
    logic [OP_W-1:0]  op;
    logic [MS_W-1:0]  ms;
    logic [CUR_W-1:0] cur;
    int               pick;
    pick = $urandom_range(99);
    if (pick < 80) op = OP_TICK;
    else if (pick < 88) op = OP_FULL;
    else if (pick < 95) op = OP_EMPTY;
    else op = OP_SPARE;
    case ($urandom_range(2))
      0: begin
        ms = MS_W'($urandom);
        cur = CUR_W'($urandom);
      end
      1: begin
        ms = MS_W'($urandom_range(255));
        cur = CUR_W'($urandom_range(4095) - 2048);
      end
      default: begin
        ms = MS_W'($urandom_range(65535, 1000));
        cur = CUR_W'($urandom_range(500000));
        if ($urandom_range(1)) cur = -cur;
      end
    endcase
    drive_item(op, ms, cur, 1'b0, '0);
  endtask

  // response side: checks every accepted result and applies backpressure
  always @(posedge clk) begin : rx_side
    logic hold_next;
    if (rst_n && out_valid && !out_stall) check_reading();
    hold_next = 1'b0;
    if (hold_req) begin
      hold_req = 1'b0;
      stall_left = LONG_HOLD;
    end
    if (stall_left > 0) begin
      stall_left--;
      hold_next = 1'b1;
    end else if (!quiet && $urandom_range(5) == 0) begin
      stall_left = $urandom_range(4);
      hold_next = 1'b1;
    end
    out_stall <= hold_next;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("run timed out after %0d cycles", cycle_cnt);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [CAP_W-1:0] cap;
    // set_cap cap op elapsed current typed | remaining soc full empty
    add_drill(0, 0,       OP_EMPTY, 0,       0,        1, 0,       0,     0, 0);
    add_drill(0, 0,       OP_TICK,  0,       0,        1, 0,       0,     0, 0);
    add_drill(0, 0,       OP_TICK,  65535,   -524288,  1, 0,       0,     0, 1);
    add_drill(0, 0,       OP_FULL,  0,       0,        1, 10000,   10000, 1, 0);
    add_drill(0, 0,       OP_TICK,  65535,   524287,   1, 10000,   10000, 1, 0);
    add_drill(0, 0,       OP_TICK,  1000,    -3600,    0, 0,       0,     0, 0);
    add_drill(0, 0,       OP_TICK,  1000,    3600,     1, 10000,   10000, 0, 0);
    add_drill(0, 0,       OP_SPARE, 65535,   -1,       1, 10000,   10000, 0, 0);
    add_drill(0, 0,       OP_TICK,  65535,   0,        1, 10000,   10000, 0, 0);
    add_drill(0, 0,       OP_TICK,  0,       -524288,  1, 10000,   10000, 0, 0);
    add_drill(0, 0,       OP_TICK,  36000,   -500000,  1, 5000,    5000,  0, 0);
    add_drill(0, 0,       OP_TICK,  36000,   -500000,  1, 0,       0,     0, 0);
    add_drill(0, 0,       OP_TICK,  1,       -1,       1, 0,       0,     0, 1);
    add_drill(0, 0,       OP_TICK,  1,       1,        1, 0,       0,     0, 0);
    add_drill(0, 0,       OP_TICK,  65535,   500000,   0, 0,       0,     0, 0);
    add_drill(0, 0,       OP_TICK,  65535,   -500000,  0, 0,       0,     0, 0);
    add_drill(0, 0,       OP_TICK,  'hAAAA,  'h55555,  0, 0,       0,     0, 0);
    add_drill(0, 0,       OP_TICK,  'h5555,  'hAAAAA,  0, 0,       0,     0, 0);
    add_drill(1, 0,       OP_FULL,  0,       0,        1, 0,       0,     1, 0);
    add_drill(0, 0,       OP_TICK,  100,     100,      1, 0,       0,     1, 0);
    add_drill(1, 1048575, OP_FULL,  0,       0,        1, 1048575, 10000, 1, 0);
    add_drill(1, 1,       OP_EMPTY, 0,       0,        1, 1048575, 10000, 0, 0);
    add_drill(0, 0,       OP_TICK,  0,       0,        1, 1,       10000, 1, 0);
    add_drill(1, 10000,   OP_TICK,  1,       -1,       0, 0,       0,     0, 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (drills[i]) begin
      if (drills[i].set_cap) write_capacity(drills[i].cap);
      drive_item(drills[i].op, drills[i].ms, drills[i].cur, drills[i].typed,
                 drills[i].want);
      if ($urandom_range(2) == 0) pause_sender($urandom_range(1, 5));
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: cap = 20'd2600;
        1: cap = 20'd1;
        2: cap = CAP_MAX;
        3: cap = '0;
        4: cap = 20'd37;
        5: cap = 20'd1000000;
        6: cap = CAP_W'($urandom_range(CAP_MAX, 1));
        7: cap = CAP_RESET;
        8: cap = CAP_W'($urandom_range(100, 1));
        default: cap = CAP_W'($urandom_range(CAP_MAX, 1));
      endcase
      write_capacity(cap);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 32 == 0) quiet = (p == PHASES - 1) || ($urandom_range(3) == 0);
        if (p == 2 && i == 40) begin
          quiet = 1'b1;
          hold_req = 1'b1;
        end
        if (p == 4 && i == 80) wait_drained();
        random_item();
        if (!quiet && $urandom_range(2) == 0) pause_sender($urandom_range(1, 5));
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("checked %0d results from %0d transactions over %0d capacity settings",
             readings, accepted, cap_settings);
    $display("expected clamps: %0d at full, %0d at empty", full_clamps, empty_clamps);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
